### rtl/pae_pkg.sv
`timescale 1ns / 1ps

package pae_pkg;

  localparam int VOICE_W    = 6;
  localparam int LEVEL_W    = 23;
  localparam int COEF_W     = 24;
  localparam int PROD_W     = LEVEL_W + COEF_W;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0] ENV_ONE            = 23'd4194304;
  localparam logic [LEVEL_W-1:0] EXP_FLOOR          = 23'd419;
  localparam logic [LEVEL_W-1:0] RESET_RELEASE_STEP = 23'd95;
  localparam logic [PROD_W-1:0]  ROUND_HALF         = PROD_W'(1) << (COEF_W - 1);

  typedef enum logic [1:0] {
    KIND_TICK        = 2'd0,
    KIND_NOTE_ON     = 2'd1,
    KIND_NOTE_OFF    = 2'd2,
    KIND_VOICE_RESET = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CFG_LINEAR_MODE  = 2'd0,
    CFG_RELEASE_STEP = 2'd1,
    CFG_RELEASE_COEF = 2'd2,
    CFG_RELEASE_BASE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    kind_t               kind;
    logic [VOICE_W-1:0]  voice;
    logic [LEVEL_W-1:0]  attack_step;
    logic [COEF_W-1:0]   attack_coef;
    logic [LEVEL_W-1:0]  attack_base;
  } item_t;

  typedef struct packed {
    logic [VOICE_W-1:0]  out_voice;
    logic [LEVEL_W-1:0]  level;
    phase_t              phase;
    logic                playing;
  } result_t;

  typedef struct packed {
    cfg_reg_t                idx;
    logic [CFG_DATA_W-1:0]   wdata;
  } cfg_req_t;

  // One voice as kept in the voice RAM
  typedef struct packed {
    phase_t              phase;
    logic [LEVEL_W-1:0]  level;
    logic [LEVEL_W-1:0]  attack_step;
    logic [COEF_W-1:0]   attack_coef;
    logic [LEVEL_W-1:0]  attack_base;
  } voice_entry_t;

endpackage

### rtl/pae_stream_if.sv
`timescale 1ns / 1ps

interface pae_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/pae_ram.sv
`timescale 1ns / 1ps

module pae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/polyphonic_ar_envelope.sv
`timescale 1ns / 1ps

// Pipeline: an accepted request reads its voice from the voice RAM; stage A multiplies the
// level by its coefficient into stage B, which writes the voice back and registers the result.
// Throughput: one request per cycle while consecutive requests address different voices and
// the output is not stalled; a request for the voice just ahead waits (RAM read-modify-write).
// Reset: configuration returns to its defaults and the per-voice valid bits clear at once,
// so every voice reads idle with level 0; no clearing pass, requests accepted right away.
module polyphonic_ar_envelope
  import pae_pkg::*;
#(
  parameter int VOICES = 64
) (
  input  logic         clk,
  input  logic         rst,
  pae_stream_if.sink   item,
  pae_stream_if.source result,
  pae_stream_if.sink   cfg
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCMP_W = 9;
  localparam logic [VCMP_W-1:0] VOICES_L = VCMP_W'(VOICES);
  localparam int REL_W = LEVEL_W + 2;

  // configuration
  logic                      linear_mode;
  logic [LEVEL_W-1:0]        release_step;
  logic [COEF_W-1:0]         release_coef;
  logic signed [LEVEL_W-1:0] release_base;

  // pipeline
  logic               accept;
  logic               advance;
  logic               a_valid;
  item_t              a_item;
  logic [VW-1:0]      a_idx;
  logic               a_inrange;
  logic               b_valid;
  kind_t              b_kind;
  logic [VOICE_W-1:0] b_voice;
  logic [VW-1:0]      b_idx;
  logic               b_inrange;
  voice_entry_t       b_cur;
  logic [LEVEL_W-1:0] b_attack_step;
  logic [COEF_W-1:0]  b_attack_coef;
  logic [LEVEL_W-1:0] b_attack_base;
  logic [PROD_W-1:0]  b_prod;
  logic               r_valid;
  result_t            r_data;

  // voice state
  logic [VOICES-1:0]  vld;
  logic               lw_valid;
  logic [VW-1:0]      lw_idx;
  voice_entry_t       lw_entry;
  logic               lw_hit;
  voice_entry_t       rdata;
  voice_entry_t       a_cur;
  logic [COEF_W-1:0]  a_coef;
  logic               wr_en;
  voice_entry_t       nxt;
  result_t            res;

  logic [PROD_W-1:0]       sum;
  logic [LEVEL_W-1:0]      rounded;
  logic [LEVEL_W:0]        att_n;
  logic signed [REL_W-1:0] rel_n;
  logic signed [REL_W-1:0] rel_floor;

  logic [VW-1:0]      in_idx;
  logic               in_inrange;
  logic               same_a;
  logic               same_b_hold;

  assign in_idx     = VW'(item.data.voice);
  assign in_inrange = VCMP_W'(item.data.voice) < VOICES_L;
  assign advance    = !r_valid || result.ready;

  // hold a request whose voice would meet its predecessor unwritten in the next stage
  assign same_a      = a_valid && (a_item.voice == item.data.voice);
  assign same_b_hold = b_valid && !advance && (b_voice == item.data.voice);
  assign item.ready  = (!a_valid || advance) && !same_a && !same_b_hold;
  assign accept      = item.valid && item.ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_mode  <= 1'b1;
      release_step <= RESET_RELEASE_STEP;
      release_coef <= '0;
      release_base <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.idx)
        CFG_LINEAR_MODE:  linear_mode  <= cfg.data.wdata[0];
        CFG_RELEASE_STEP: release_step <= cfg.data.wdata[LEVEL_W-1:0];
        CFG_RELEASE_COEF: release_coef <= cfg.data.wdata[COEF_W-1:0];
        CFG_RELEASE_BASE: release_base <= $signed(cfg.data.wdata[LEVEL_W-1:0]);
        default: ;
      endcase
    end
  end

  pae_ram #(
    .WIDTH($bits(voice_entry_t)),
    .DEPTH(VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (b_idx),
    .wdata (nxt),
    .re    (accept),
    .raddr (in_idx),
    .rdata (rdata)
  );

  // stage A: pick up the voice, forwarding a write made at the read edge
  assign lw_hit = lw_valid && (lw_idx == a_idx);

  always_comb begin
    a_cur = rdata;
    if (!vld[a_idx]) begin
      a_cur.phase = PH_IDLE;
      a_cur.level = '0;
    end
    if (lw_hit) begin
      a_cur = lw_entry;
    end
    a_coef = (a_cur.phase == PH_ATTACK) ? a_cur.attack_coef : release_coef;
  end

  // stage B: finish the step and build the write-back entry
  always_comb begin
    sum       = b_prod + ROUND_HALF;
    rounded   = sum[PROD_W-1:COEF_W];
    att_n     = linear_mode ? ({1'b0, b_cur.level} + {1'b0, b_cur.attack_step})
                            : ({1'b0, rounded} + {1'b0, b_cur.attack_base});
    rel_n     = linear_mode ? ($signed({2'b00, b_cur.level}) - $signed({2'b00, release_step}))
                            : ($signed({2'b00, rounded})
                               + $signed({{2{release_base[LEVEL_W-1]}}, release_base}));
    rel_floor = linear_mode ? '0 : $signed({2'b00, EXP_FLOOR});
    nxt = b_cur;
    case (b_kind)
      KIND_TICK: begin
        if (b_cur.phase == PH_ATTACK) begin
          if (att_n >= {1'b0, ENV_ONE}) begin
            nxt.level = ENV_ONE;
            nxt.phase = PH_SUSTAIN;
          end else begin
            nxt.level = att_n[LEVEL_W-1:0];
          end
        end else if (b_cur.phase == PH_RELEASE) begin
          if (rel_n <= rel_floor) begin
            nxt.level = '0;
            nxt.phase = PH_IDLE;
          end else if (rel_n > $signed({2'b00, ENV_ONE})) begin
            nxt.level = ENV_ONE;
          end else begin
            nxt.level = rel_n[LEVEL_W-1:0];
          end
        end
      end
      KIND_NOTE_ON: begin
        nxt.phase       = PH_ATTACK;
        nxt.level       = '0;
        nxt.attack_step = b_attack_step;
        nxt.attack_coef = b_attack_coef;
        nxt.attack_base = b_attack_base;
      end
      KIND_NOTE_OFF: begin
        nxt.phase = PH_RELEASE;
      end
      KIND_VOICE_RESET: begin
        nxt.phase = PH_IDLE;
        nxt.level = '0;
      end
      default: ;
    endcase
    res.out_voice = b_voice;
    res.level     = b_inrange ? nxt.level : '0;
    res.phase     = b_inrange ? nxt.phase : PH_IDLE;
    res.playing   = b_inrange && (nxt.phase != PH_IDLE);
  end

  assign wr_en = b_valid && advance && b_inrange;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      r_valid  <= 1'b0;
      lw_valid <= 1'b0;
      vld      <= '0;
    end else begin
      a_valid <= accept || (a_valid && !advance);
      if (advance) begin
        b_valid <= a_valid;
        r_valid <= b_valid;
      end
      if (wr_en) begin
        vld[b_idx] <= 1'b1;
        lw_valid   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item    <= item.data;
      a_idx     <= in_idx;
      a_inrange <= in_inrange;
    end
    if (advance) begin
      b_kind        <= a_item.kind;
      b_voice       <= a_item.voice;
      b_idx         <= a_idx;
      b_inrange     <= a_inrange;
      b_cur         <= a_cur;
      b_attack_step <= a_item.attack_step;
      b_attack_coef <= a_item.attack_coef;
      b_attack_base <= a_item.attack_base;
      b_prod        <= PROD_W'(a_cur.level) * PROD_W'(a_coef);
      if (b_valid) begin
        r_data <= res;
      end
    end
    if (wr_en) begin
      lw_idx   <= b_idx;
      lw_entry <= nxt;
    end
  end

  assign result.valid = r_valid;
  assign result.data  = r_data;

  a_no_voice_overlap: assert property (@(posedge clk) disable iff (rst)
    a_valid && b_valid |-> a_item.voice != b_voice)
    else $error("same voice in read and write-back stages");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> vld[$past(b_idx)])
    else $error("voice written but valid bit not set");

  a_forward_valid: assert property (@(posedge clk) disable iff (rst)
    a_valid && lw_hit |-> vld[a_idx])
    else $error("forwarded voice without valid bit");

  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> r_data.level <= ENV_ONE && r_data.playing == (r_data.phase != PH_IDLE))
    else $error("result level or playing flag inconsistent");

endmodule

### sim/polyphonic_ar_envelope_tb.sv
`timescale 1ns / 1ps

module polyphonic_ar_envelope_tb;
  import pae_pkg::*;

  localparam int NVOICE      = 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF    = 400;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 158;
  localparam logic [LEVEL_W-1:0] ATTACK_BASE_MAX = 23'd5452595;

  typedef struct {
    logic               lin;
    kind_t              kind;
    logic [VOICE_W-1:0] voice;
    logic [LEVEL_W-1:0] step;
    logic [COEF_W-1:0]  coef;
    logic [LEVEL_W-1:0] base;
    bit                 typed;
    logic [LEVEL_W-1:0] level;
    phase_t             phase;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  pae_stream_if #(.payload_t(item_t))    item_if ();
  pae_stream_if #(.payload_t(result_t))  res_if ();
  pae_stream_if #(.payload_t(cfg_req_t)) cfg_if ();

  polyphonic_ar_envelope #(.VOICES(NVOICE)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // Envelope state as the block should hold it
  logic               lin_mode;
  logic [LEVEL_W-1:0] rel_step;
  logic [COEF_W-1:0]  rel_coef;
  int                 rel_base;
  phase_t             v_phase    [NVOICE];
  logic [LEVEL_W-1:0] v_level    [NVOICE];
  logic [LEVEL_W-1:0] v_atk_step [NVOICE];
  logic [COEF_W-1:0]  v_atk_coef [NVOICE];
  logic [LEVEL_W-1:0] v_atk_base [NVOICE];

  result_t due_levels [$];
  int      errors    = 0;
  int      quiet     = 0;
  int      pool_lo   = 0;
  bit      tx_burst  = 1'b0;
  bit      rx_burst  = 1'b0;
  bit      stall_req = 1'b0;

  dir_row_t dir_tab [25] = '{
    '{1'b1, KIND_TICK,        6'd0,  23'd0,       24'd0,      23'd0,       1'b1, 23'd0,    PH_IDLE},
    '{1'b1, KIND_TICK,        6'd63, 23'd0,       24'd0,      23'd0,       1'b1, 23'd0,    PH_IDLE},
    '{1'b1, KIND_NOTE_ON,     6'd0,  ENV_ONE,     24'hFFFFFF, ATTACK_BASE_MAX, 1'b1, 23'd0, PH_ATTACK},
    '{1'b1, KIND_TICK,        6'd0,  23'd0,       24'd0,      23'd0,       1'b1, ENV_ONE,  PH_SUSTAIN},
    '{1'b1, KIND_TICK,        6'd0,  23'd0,       24'd0,      23'd0,       1'b1, ENV_ONE,  PH_SUSTAIN},
    '{1'b1, KIND_NOTE_OFF,    6'd0,  23'd0,       24'd0,      23'd0,       1'b1, ENV_ONE,  PH_RELEASE},
    '{1'b1, KIND_TICK,        6'd0,  23'd0,       24'd0,      23'd0,       1'b1, 23'd4194209,
      PH_RELEASE},
    // retrigger while releasing: voice restarts from zero
    '{1'b1, KIND_NOTE_ON,     6'd0,  23'd1,       24'd0,      23'd0,       1'b1, 23'd0,    PH_ATTACK},
    '{1'b1, KIND_NOTE_ON,     6'd63, 23'h3FFFFF,  24'd0,      23'd0,       1'b1, 23'd0,    PH_ATTACK},
    '{1'b1, KIND_TICK,        6'd63, 23'd0,       24'd0,      23'd0,       1'b1, 23'h3FFFFF,
      PH_ATTACK},
    '{1'b1, KIND_TICK,        6'd63, 23'd0,       24'd0,      23'd0,       1'b1, ENV_ONE,  PH_SUSTAIN},
    '{1'b1, KIND_VOICE_RESET, 6'd63, 23'd0,       24'd0,      23'd0,       1'b1, 23'd0,    PH_IDLE},
    '{1'b1, KIND_NOTE_OFF,    6'd5,  23'd0,       24'd0,      23'd0,       1'b1, 23'd0,    PH_RELEASE},
    '{1'b1, KIND_TICK,        6'd5,  23'd0,       24'd0,      23'd0,       1'b1, 23'd0,    PH_IDLE},
    '{1'b1, KIND_NOTE_ON,     6'd1,  23'h2AAAAA,  24'h555555, 23'h155555,  1'b0, 23'd0,    PH_IDLE},
    '{1'b1, KIND_TICK,        6'd1,  23'h555555,  24'hAAAAAA, 23'h2AAAAA,  1'b0, 23'd0,    PH_IDLE},
    '{1'b1, KIND_NOTE_OFF,    6'd1,  23'd0,       24'd0,      23'd0,       1'b0, 23'd0,    PH_IDLE},
    '{1'b1, KIND_TICK,        6'd1,  23'd0,       24'd0,      23'd0,       1'b0, 23'd0,    PH_IDLE},
    // exponential, release coefficient one half, no offset
    '{1'b0, KIND_NOTE_ON,     6'd2,  23'd0,       24'd0,      23'd840,     1'b1, 23'd0,    PH_ATTACK},
    '{1'b0, KIND_TICK,        6'd2,  23'd0,       24'd0,      23'd0,       1'b1, 23'd840,  PH_ATTACK},
    '{1'b0, KIND_NOTE_OFF,    6'd2,  23'd0,       24'd0,      23'd0,       1'b1, 23'd840,  PH_RELEASE},
    '{1'b0, KIND_TICK,        6'd2,  23'd0,       24'd0,      23'd0,       1'b1, 23'd420,  PH_RELEASE},
    '{1'b0, KIND_TICK,        6'd2,  23'd0,       24'd0,      23'd0,       1'b1, 23'd0,    PH_IDLE},
    '{1'b0, KIND_NOTE_ON,     6'd3,  23'd0,       24'hFFFFFF, ATTACK_BASE_MAX, 1'b1, 23'd0, PH_ATTACK},
    '{1'b0, KIND_TICK,        6'd3,  23'd0,       24'd0,      23'd0,       1'b1, ENV_ONE,  PH_SUSTAIN}
  };

  // Q1.22 times Q0.24, rounded half up back to Q1.22
  function automatic longint scale_q24(logic [LEVEL_W-1:0] lv, logic [COEF_W-1:0] c);
    return (longint'(lv) * longint'(c) + 64'sd8388608) >>> 24;
  endfunction

  function automatic result_t advance_voice(item_t it);
    result_t            r;
    longint             n;
    longint             flo;
    logic [VOICE_W-1:0] v;
    v = it.voice;
    case (it.kind)
      KIND_TICK: begin
        if (v_phase[v] == PH_ATTACK) begin
          if (lin_mode)
            n = longint'(v_level[v]) + longint'(v_atk_step[v]);
          else
            n = scale_q24(v_level[v], v_atk_coef[v]) + longint'(v_atk_base[v]);
          if (n >= longint'(ENV_ONE)) begin
            v_level[v] = ENV_ONE;
            v_phase[v] = PH_SUSTAIN;
          end else begin
            v_level[v] = n[LEVEL_W-1:0];
          end
        end else if (v_phase[v] == PH_RELEASE) begin
          if (lin_mode) begin
            n   = longint'(v_level[v]) - longint'(rel_step);
            flo = 0;
          end else begin
            n   = scale_q24(v_level[v], rel_coef) + longint'(rel_base);
            flo = longint'(EXP_FLOOR);
          end
          if (n <= flo) begin
            v_level[v] = '0;
            v_phase[v] = PH_IDLE;
          end else if (n > longint'(ENV_ONE)) begin
            v_level[v] = ENV_ONE;
          end else begin
            v_level[v] = n[LEVEL_W-1:0];
          end
        end
      end
      KIND_NOTE_ON: begin
        v_level[v]    = '0;
        v_phase[v]    = PH_ATTACK;
        v_atk_step[v] = it.attack_step;
        v_atk_coef[v] = it.attack_coef;
        v_atk_base[v] = it.attack_base;
      end
      KIND_NOTE_OFF: v_phase[v] = PH_RELEASE;
      default: begin
        v_phase[v] = PH_IDLE;
        v_level[v] = '0;
      end
    endcase
    r.out_voice = v;
    r.level     = v_level[v];
    r.phase     = v_phase[v];
    r.playing   = (v_phase[v] != PH_IDLE);
    return r;
  endfunction

  // Mostly well-formed note lifecycles on a small voice pool, some noise
  function automatic item_t pick_request();
    item_t it;
    int    roll;
    it.voice = ($urandom_range(0, 9) == 0) ? VOICE_W'($urandom_range(0, NVOICE - 1))
                                           : VOICE_W'(pool_lo + $urandom_range(0, 5));
    if ($urandom_range(0, 99) < 8) begin
      it.kind        = kind_t'($urandom_range(0, 3));
      it.attack_step = LEVEL_W'($urandom_range(0, ENV_ONE));
      it.attack_coef = COEF_W'($urandom());
      it.attack_base = LEVEL_W'($urandom_range(0, ATTACK_BASE_MAX));
      return it;
    end
    roll = $urandom_range(0, 99);
    case (v_phase[it.voice])
      PH_IDLE:
        it.kind = (roll < 70) ? KIND_NOTE_ON : (roll < 92) ? KIND_TICK :
                  (roll < 96) ? KIND_NOTE_OFF : KIND_VOICE_RESET;
      PH_ATTACK:
        it.kind = (roll < 86) ? KIND_TICK : (roll < 94) ? KIND_NOTE_ON :
                  (roll < 98) ? KIND_NOTE_OFF : KIND_VOICE_RESET;
      PH_SUSTAIN:
        it.kind = (roll < 45) ? KIND_TICK : (roll < 92) ? KIND_NOTE_OFF :
                  (roll < 97) ? KIND_NOTE_ON : KIND_VOICE_RESET;
      default:
        it.kind = (roll < 85) ? KIND_TICK : (roll < 95) ? KIND_NOTE_ON :
                  (roll < 98) ? KIND_NOTE_OFF : KIND_VOICE_RESET;
    endcase
    roll = $urandom_range(0, 99);
    it.attack_step = (roll < 5)  ? LEVEL_W'(0) :
                     (roll < 15) ? ENV_ONE :
                     LEVEL_W'($urandom_range(ENV_ONE / 32, ENV_ONE - 1));
    it.attack_coef = COEF_W'($urandom_range(24'hC00000, 24'hFFFFFF));
    it.attack_base = (roll > 90) ? ATTACK_BASE_MAX :
                     LEVEL_W'($urandom_range(ENV_ONE / 4, ATTACK_BASE_MAX));
    return it;
  endfunction

  task automatic send_request(input item_t it, input bit typed, input result_t want);
    int      gap;
    result_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk); while (!item_if.ready);
    pred = advance_voice(it);
    due_levels.push_back(typed ? want : pred);
  endtask

  // Leaves valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{idx: idx, wdata: d};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_LINEAR_MODE:  lin_mode = d[0];
      CFG_RELEASE_STEP: rel_step = d[LEVEL_W-1:0];
      CFG_RELEASE_COEF: rel_coef = d;
      default:          rel_base = $signed(d[LEVEL_W-1:0]);
    endcase
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (due_levels.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (due_levels.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result voice %0d level %0d phase %0d", $realtime,
                 got.out_voice, got.level, got.phase);
      return;
    end
    want = due_levels.pop_front();
    if (got.out_voice !== want.out_voice || got.level !== want.level ||
        got.phase !== want.phase || got.playing !== want.playing) begin
      errors++;
      if (errors <= 10)
        $display("%0t: expected voice %0d level %0d phase %0d playing %0d, got %0d %0d %0d %0d",
                 $realtime, want.out_voice, want.level, want.phase, want.playing,
                 got.out_voice, got.level, got.phase, got.playing);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("** polyphonic_ar_envelope: FAILED **");
      $finish;
    end
  end

  initial begin
    int rx_count;
    int gap;
    rx_count = 0;
    res_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (stall_req) begin
        // hold off long enough for the block to back up into its input
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        stall_req = 1'b0;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      check_result(res_if.data);
      rx_count++;
      if (rx_count % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    item_t              it;
    result_t            want;
    logic               s_lin;
    logic [LEVEL_W-1:0] s_step;
    logic [COEF_W-1:0]  s_coef;
    int                 s_base;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    lin_mode = 1'b1;
    rel_step = RESET_RELEASE_STEP;
    rel_coef = '0;
    rel_base = 0;
    for (int v = 0; v < NVOICE; v++) begin
      v_phase[v]    = PH_IDLE;
      v_level[v]    = '0;
      v_atk_step[v] = '0;
      v_atk_coef[v] = '0;
      v_atk_base[v] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].lin != lin_mode) begin
        settle();
        write_reg(CFG_LINEAR_MODE, CFG_DATA_W'(dir_tab[i].lin));
        write_reg(CFG_RELEASE_COEF, 24'h800000);
        write_reg(CFG_RELEASE_BASE, '0);
        cfg_if.valid <= 1'b0;
      end
      it   = '{kind: dir_tab[i].kind, voice: dir_tab[i].voice,
               attack_step: dir_tab[i].step, attack_coef: dir_tab[i].coef,
               attack_base: dir_tab[i].base};
      want = '{out_voice: dir_tab[i].voice, level: dir_tab[i].level,
               phase: dir_tab[i].phase, playing: dir_tab[i].phase != PH_IDLE};
      send_request(it, dir_tab[i].typed, want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          s_lin = 1'b1; s_step = ENV_ONE; s_coef = '0; s_base = -4194304;
        end
        1: begin
          s_lin = 1'b0; s_step = '0; s_coef = 24'hFFFFFF; s_base = 0;
        end
        2: begin
          s_lin = 1'b0; s_step = ENV_ONE; s_coef = '0; s_base = -4194304;
        end
        3: begin
          s_lin = 1'b1; s_step = '0; s_coef = 24'hFFFFFF; s_base = 0;
        end
        default: begin
          s_lin  = 1'($urandom_range(0, 1));
          s_step = LEVEL_W'($urandom_range(ENV_ONE / 64, ENV_ONE * 3 / 4));
          s_coef = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom())
                                               : COEF_W'($urandom_range(24'hA00000, 24'hF80000));
          s_base = -int'($urandom_range(0, 20000));
        end
      endcase
      settle();
      write_reg(CFG_LINEAR_MODE, CFG_DATA_W'(s_lin));
      write_reg(CFG_RELEASE_STEP, CFG_DATA_W'(s_step));
      write_reg(CFG_RELEASE_COEF, s_coef);
      write_reg(CFG_RELEASE_BASE, CFG_DATA_W'(s_base));
      cfg_if.valid <= 1'b0;
      pool_lo = $urandom_range(0, NVOICE - 6);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        if (p == 4 && k == 40) begin
          stall_req = 1'b1;
          tx_burst  = 1'b1;
        end
        it = pick_request();
        send_request(it, 1'b0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0 && due_levels.size() == 0)
      $display("** polyphonic_ar_envelope: PASSED **");
    else
      $display("** polyphonic_ar_envelope: FAILED **");
    $finish;
  end

endmodule
